@@ rtl/core/arp_pkg.sv @@
// ----------------------------------------------------------------------------
// ARP cache package
// Shared widths, command and status codes, slot layout, controller state and
// the command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package arp_pkg;

   localparam int ARP_BUCKETS = 16;
   localparam int ARP_WAYS    = 4;

   localparam int CMD_W    = 2;
   localparam int IP_W     = 32;
   localparam int MAC_W    = 48;
   localparam int STATUS_W = 2;

   // Address bits consumed by the remainder unit in one cycle.
   localparam int REM_DIGIT_W = 8;

   localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_UNRESOLVED = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;

   typedef struct packed {
      logic             valid;
      logic             resolved;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } slot_type;

   typedef enum logic [2:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_REM,
      FSM_READ,
      FSM_UPDATE
   } arp_state_type;

   typedef struct packed {
      logic load;
      logic rem_step;
      logic rd_en;
      logic update;
      logic clear_en;
   } arp_cmd_type;

   typedef struct packed {
      logic rem_done;
      logic clear_last;
   } arp_stat_type;

endpackage

@@ rtl/core/arp_req_if.sv @@
// ----------------------------------------------------------------------------
// ARP cache request channel
// Valid/ready channel carrying one command with its address and MAC.
// ----------------------------------------------------------------------------
interface arp_req_if
   import arp_pkg::*;
   ;
   logic             valid;
   logic             ready;
   logic [CMD_W-1:0] command;
   logic [IP_W-1:0]  ip_addr;
   logic [MAC_W-1:0] mac_in;

   modport source (output valid, output command, output ip_addr, output mac_in,
                   input ready);
   modport sink   (input valid, input command, input ip_addr, input mac_in,
                   output ready);
endinterface

@@ rtl/core/arp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ARP cache response channel
// Valid/ready channel carrying one status code and the returned MAC.
// ----------------------------------------------------------------------------
interface arp_rsp_if
   import arp_pkg::*;
   ;
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [MAC_W-1:0]    mac_out;

   modport source (output valid, output status, output mac_out, input ready);
   modport sink   (input valid, input status, input mac_out, output ready);
endinterface

@@ rtl/core/arp_hash_table_top.sv @@
// ----------------------------------------------------------------------------
// Flow: after a request transfer the remainder unit runs when BUCKETS is not a
// power of two (eight address bits per cycle), the bucket row is read, then the
// row is written back and the response register loaded once it holds no unread
// response. A new command can be accepted in the write-back cycle, not before.
// Reset: a clearing pass writes every bucket row, with no request accepted
// during it.
// ----------------------------------------------------------------------------
// ARP cache top level
// Set-associative IPv4 to MAC cache with add, lookup and delete commands.
// ----------------------------------------------------------------------------
module arp_hash_table_top
   import arp_pkg::*;
#(
   parameter int BUCKETS = ARP_BUCKETS,
   parameter int WAYS    = ARP_WAYS
) (
   input  logic        clock,
   input  logic        reset,
   arp_req_if.sink     req_chan,
   arp_rsp_if.source   rsp_chan
);

   arp_cmd_type  cmd;
   arp_stat_type stat;

   arp_ctrl #(
      .BUCKETS (BUCKETS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   arp_dp #(
      .BUCKETS (BUCKETS),
      .WAYS    (WAYS)
   ) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_command (req_chan.command),
      .req_ip_addr (req_chan.ip_addr),
      .req_mac_in  (req_chan.mac_in),
      .rsp_status  (rsp_chan.status),
      .rsp_mac_out (rsp_chan.mac_out)
   );

   a_no_accept_in_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.clear_en |-> !req_chan.ready && !cmd.update)
      else $error("request accepted or row updated during the clearing pass");

   a_no_rsp_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.update |-> (!rsp_chan.valid || rsp_chan.ready))
      else $error("response register loaded while holding an unread response");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> (rsp_chan.status == ST_OK || rsp_chan.status == ST_UNRESOLVED ||
                          rsp_chan.status == ST_FULL))
      else $error("response carries an undefined status code");

   a_mac_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && (rsp_chan.status != ST_OK) |-> (rsp_chan.mac_out == '0))
      else $error("nonzero MAC returned with a non-ok status");

endmodule

@@ rtl/core/arp_rem.sv @@
// ----------------------------------------------------------------------------
// ARP bucket index unit
// Computes the address modulo the bucket count. A power-of-two count is a
// mask registered on load, ready in the following cycle; otherwise a
// restoring remainder runs over several address bits per cycle.
// ----------------------------------------------------------------------------
module arp_rem
   import arp_pkg::*;
#(
   parameter int  BUCKETS  = ARP_BUCKETS,
   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  logic                step,
   input  logic [IP_W-1:0]     value,
   output logic [BUCKET_W-1:0] rem,
   output logic                done
);

   localparam bit POW2       = ((BUCKETS & (BUCKETS - 1)) == 0);
   localparam int REM_CYCLES = IP_W / REM_DIGIT_W;
   localparam int CNT_W      = $clog2(REM_CYCLES + 1);

   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      count_in = count_ff;
      if (load) begin
         count_in = POW2 ? '0 : CNT_W'(REM_CYCLES);
      end else if (step && (count_ff != '0)) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign done = (count_ff == '0);

   if (POW2) begin : g_mask
      logic [BUCKET_W-1:0] rem_ff;

      always_ff @(posedge clock) begin
         if (load) begin
            rem_ff <= BUCKET_W'(value & IP_W'(BUCKETS - 1));
         end
      end

      assign rem = rem_ff;
   end else begin : g_div
      logic [IP_W-1:0]     shift_ff, shift_in;
      logic [BUCKET_W-1:0] part_ff, part_in;
      logic [BUCKET_W:0]   trial;

      always_comb begin
         shift_in = shift_ff;
         part_in  = part_ff;
         trial    = '0;
         if (load) begin
            shift_in = value;
            part_in  = '0;
         end else if (step && !done) begin
            for (int i = 0; i < REM_DIGIT_W; i++) begin
               trial    = {part_in, shift_in[IP_W-1]};
               shift_in = {shift_in[IP_W-2:0], 1'b0};
               if (trial >= (BUCKET_W + 1)'(BUCKETS)) begin
                  trial = trial - (BUCKET_W + 1)'(BUCKETS);
               end
               part_in = trial[BUCKET_W-1:0];
            end
         end
      end

      always_ff @(posedge clock) begin
         shift_ff <= shift_in;
         part_ff  <= part_in;
      end

      assign rem = part_ff;
   end

endmodule

@@ rtl/core/arp_dp.sv @@
// ----------------------------------------------------------------------------
// ARP cache datapath
// Holds the bucket memory, the captured command, the bucket index unit, the
// parallel tag compare with way selection, and the response register.
// ----------------------------------------------------------------------------
module arp_dp
   import arp_pkg::*;
#(
   parameter int  BUCKETS  = ARP_BUCKETS,
   parameter int  WAYS     = ARP_WAYS,
   localparam int BUCKET_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
   localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1
) (
   input  logic                clock,
   input  logic                reset,
   input  arp_cmd_type         cmd,
   output arp_stat_type        stat,
   input  logic [CMD_W-1:0]    req_command,
   input  logic [IP_W-1:0]     req_ip_addr,
   input  logic [MAC_W-1:0]    req_mac_in,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [MAC_W-1:0]    rsp_mac_out
);

   logic [CMD_W-1:0]    command_ff;
   logic [IP_W-1:0]     ip_ff;
   logic [MAC_W-1:0]    mac_ff;
   logic [BUCKET_W-1:0] bucket;
   logic                rem_done;
   logic [BUCKET_W-1:0] clear_cnt_ff, clear_cnt_in;

   slot_type [WAYS-1:0] mem [BUCKETS];
   slot_type [WAYS-1:0] row_ff;
   slot_type [WAYS-1:0] new_row;
   slot_type [WAYS-1:0] mem_wdata;
   logic [BUCKET_W-1:0] mem_addr;
   logic                mem_we;

   logic [WAYS-1:0]     hit_vec, free_vec;
   logic                hit_found, free_found;
   logic [WAY_W-1:0]    hit_way, free_way, sel_way;
   slot_type            sel_slot;

   logic [STATUS_W-1:0] status_in;
   logic [MAC_W-1:0]    mac_res;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [MAC_W-1:0]    rsp_mac_ff;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         command_ff <= req_command;
         ip_ff      <= req_ip_addr;
         mac_ff     <= req_mac_in;
      end
   end

   arp_rem #(
      .BUCKETS (BUCKETS)
   ) u_rem (
      .clock (clock),
      .reset (reset),
      .load  (cmd.load),
      .step  (cmd.rem_step),
      .value (req_ip_addr),
      .rem   (bucket),
      .done  (rem_done)
   );

   always_comb begin
      clear_cnt_in = clear_cnt_ff;
      if (cmd.clear_en) begin
         clear_cnt_in = clear_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_cnt_ff <= '0;
      end else begin
         clear_cnt_ff <= clear_cnt_in;
      end
   end

   assign stat = '{rem_done: rem_done, clear_last: (clear_cnt_ff == BUCKET_W'(BUCKETS - 1))};

   assign mem_we    = cmd.update || cmd.clear_en;
   assign mem_addr  = cmd.clear_en ? clear_cnt_ff : bucket;
   assign mem_wdata = cmd.clear_en ? '0 : new_row;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_addr] <= mem_wdata;
      end
      if (cmd.rd_en) begin
         row_ff <= mem[bucket];
      end
   end

   always_comb begin
      for (int w = 0; w < WAYS; w++) begin
         hit_vec[w]  = row_ff[w].valid && (row_ff[w].ip == ip_ff);
         free_vec[w] = !row_ff[w].valid;
      end
   end

   // Lowest-numbered way wins in both searches.
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = WAYS - 1; w >= 0; w--) begin
         if (hit_vec[w]) begin
            hit_way = WAY_W'(w);
         end
         if (free_vec[w]) begin
            free_way = WAY_W'(w);
         end
      end
   end

   assign hit_found  = |hit_vec;
   assign free_found = |free_vec;
   assign sel_way    = hit_found ? hit_way : free_way;
   assign sel_slot   = row_ff[sel_way];

   always_comb begin
      new_row   = row_ff;
      status_in = ST_OK;
      mac_res   = '0;
      unique case (command_ff)
         CMD_ADD: begin
            if (!hit_found && !free_found) begin
               status_in = ST_FULL;
            end else begin
               new_row[sel_way] = '{valid: 1'b1, resolved: 1'b1, ip: ip_ff, mac: mac_ff};
            end
         end
         CMD_LOOKUP: begin
            if (hit_found) begin
               if (sel_slot.resolved) begin
                  mac_res = sel_slot.mac;
               end else begin
                  status_in = ST_UNRESOLVED;
               end
            end else if (free_found) begin
               new_row[sel_way] = '{valid: 1'b1, resolved: 1'b0, ip: ip_ff, mac: '0};
               status_in        = ST_UNRESOLVED;
            end else begin
               status_in = ST_FULL;
            end
         end
         CMD_DELETE: begin
            if (hit_found) begin
               new_row[hit_way].valid    = 1'b0;
               new_row[hit_way].resolved = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_status_ff <= status_in;
         rsp_mac_ff    <= mac_res;
      end
   end

   assign rsp_status  = rsp_status_ff;
   assign rsp_mac_out = rsp_mac_ff;

endmodule

@@ rtl/core/arp_ctrl.sv @@
// ----------------------------------------------------------------------------
// ARP cache controller
// Sequences the clearing pass, command capture, bucket index computation,
// bucket read and write-back, and owns the response valid flag.
// ----------------------------------------------------------------------------
module arp_ctrl
   import arp_pkg::*;
#(
   parameter int BUCKETS = ARP_BUCKETS
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  arp_stat_type stat,
   output arp_cmd_type  cmd
);

   localparam bit POW2 = ((BUCKETS & (BUCKETS - 1)) == 0);

   arp_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          out_free;
   logic          accept;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == FSM_IDLE) || ((state_ff == FSM_UPDATE) && out_free);
   assign accept    = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_CLEAR: begin
            if (stat.clear_last) begin
               state_in = FSM_IDLE;
            end
         end
         FSM_IDLE: begin
            if (accept) begin
               state_in = POW2 ? FSM_READ : FSM_REM;
            end
         end
         FSM_REM: begin
            if (stat.rem_done) begin
               state_in = FSM_READ;
            end
         end
         FSM_READ: begin
            state_in = FSM_UPDATE;
         end
         FSM_UPDATE: begin
            if (out_free) begin
               if (accept) begin
                  state_in = POW2 ? FSM_READ : FSM_REM;
               end else begin
                  state_in = FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.load     = accept;
      cmd.rem_step = (state_ff == FSM_REM);
      cmd.rd_en    = (state_ff == FSM_READ);
      cmd.update   = (state_ff == FSM_UPDATE) && out_free;
      cmd.clear_en = (state_ff == FSM_CLEAR);
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.update) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
